[hdl/osq_pkg.sv]
package osq_pkg;

  // default number of stored entries
  localparam int unsigned CAPACITY = 32;

  // width of one stored value
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

endpackage

[hdl/osq_if.sv]
// command channel
interface osq_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic signed [osq_pkg::DATA_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// result channel
interface osq_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [osq_pkg::DATA_W-1:0]  entry;
  logic                               entry_present;
  logic                               last;

  modport source (output valid, output status, output entry, output entry_present,
                  output last, input ready);
  modport sink   (input valid, input status, input entry, input entry_present,
                  input last, output ready);
endinterface

[hdl/osq_mem.sv]
module osq_mem #(
  parameter int unsigned DEPTH = osq_pkg::CAPACITY,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [osq_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [osq_pkg::DATA_W-1:0] rdata_o
);

  logic [osq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [osq_pkg::DATA_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/osq_ctrl.sv]
module osq_ctrl #(
  parameter int unsigned CAPACITY = osq_pkg::CAPACITY,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  osq_cmd_if.sink                    cmd_i,
  osq_res_if.source                  res_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [osq_pkg::DATA_W-1:0] mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [osq_pkg::DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_INS,
    S_DEL,
    S_DUMP
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [osq_pkg::DATA_W-1:0]  value_q, value_d;
  logic [osq_pkg::DATA_W-1:0]  carry_q, carry_d;
  logic                        found_q, found_d;
  osq_pkg::status_e            resp_q, resp_d;

  logic                        out_valid_q, out_valid_d;
  osq_pkg::status_e            out_status_q, out_status_d;
  logic [osq_pkg::DATA_W-1:0]  out_entry_q, out_entry_d;
  logic                        out_present_q, out_present_d;
  logic                        out_last_q, out_last_d;

  logic                        can_emit;
  logic                        full;
  logic                        idx_at_end;
  logic [CW-1:0]               idx_inc;
  logic [CW-1:0]               idx_dec;
  osq_pkg::action_e            action;

  assign can_emit   = !out_valid_q || res_o.ready;
  assign full       = (count_q == CW'(CAPACITY));
  assign idx_at_end = (idx_q == count_q);
  assign idx_inc    = idx_q + CW'(1);
  assign idx_dec    = idx_q - CW'(1);
  assign action     = osq_pkg::action_e'(cmd_i.action);

  assign cmd_i.ready = (state_q == S_IDLE);

  // next state, memory access and result loading
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    value_d       = value_q;
    carry_d       = carry_q;
    found_d       = found_q;
    resp_d        = resp_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_entry_d   = out_entry_q;
    out_present_d = out_present_q;
    out_last_d    = out_last_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = idx_q[AW-1:0];
    mem_wdata_o   = carry_q;
    mem_raddr_o   = '0;

    // result taken by the receiver
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          value_d = cmd_i.value;
          carry_d = cmd_i.value;
          idx_d   = '0;
          found_d = 1'b0;
          resp_d  = osq_pkg::ST_DONE;
          case (action)
            osq_pkg::ACT_APPEND: begin
              state_d = S_RESP;
              if (full) begin
                resp_d = osq_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AW-1:0];
                mem_wdata_o = cmd_i.value;
                count_d     = count_q + CW'(1);
              end
            end
            osq_pkg::ACT_INSERT: begin
              if (full) begin
                resp_d  = osq_pkg::ST_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_INS;
              end
            end
            osq_pkg::ACT_DELETE: begin
              state_d = S_DEL;
            end
            osq_pkg::ACT_DUMP: begin
              state_d = (count_q == '0) ? S_RESP : S_DUMP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // single status transaction
      S_RESP: begin
        if (can_emit) begin
          out_valid_d   = 1'b1;
          out_status_d  = resp_q;
          out_entry_d   = '0;
          out_present_d = 1'b0;
          out_last_d    = 1'b1;
          state_d       = S_IDLE;
        end
      end

      // forward scan, once placed every later entry moves up by one
      S_INS: begin
        mem_raddr_o = idx_inc[AW-1:0];
        if (idx_at_end) begin
          if (can_emit) begin
            mem_we_o      = 1'b1;
            mem_wdata_o   = carry_q;
            count_d       = count_q + CW'(1);
            out_valid_d   = 1'b1;
            out_status_d  = osq_pkg::ST_DONE;
            out_entry_d   = '0;
            out_present_d = 1'b0;
            out_last_d    = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          if (found_q || !($signed(mem_rdata_i) < $signed(value_q))) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = carry_q;
            carry_d     = mem_rdata_i;
            found_d     = 1'b1;
          end
          idx_d = idx_inc;
        end
      end

      // forward scan, after the match every entry moves down by one
      S_DEL: begin
        mem_raddr_o = idx_inc[AW-1:0];
        if (idx_at_end) begin
          if (can_emit) begin
            out_valid_d   = 1'b1;
            out_status_d  = found_q ? osq_pkg::ST_DONE : osq_pkg::ST_NOT_FOUND;
            out_entry_d   = '0;
            out_present_d = 1'b0;
            out_last_d    = 1'b1;
            if (found_q) begin
              count_d = count_q - CW'(1);
            end
            state_d = S_IDLE;
          end
        end else begin
          if (found_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_dec[AW-1:0];
            mem_wdata_o = mem_rdata_i;
          end else if (mem_rdata_i == value_q) begin
            found_d = 1'b1;
          end
          idx_d = idx_inc;
        end
      end

      // one entry per transaction, re-read the same entry while stalled
      S_DUMP: begin
        mem_raddr_o = idx_q[AW-1:0];
        if (can_emit) begin
          out_valid_d   = 1'b1;
          out_status_d  = osq_pkg::ST_DONE;
          out_entry_d   = mem_rdata_i;
          out_present_d = 1'b1;
          out_last_d    = (idx_inc == count_q);
          if (idx_inc == count_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d       = idx_inc;
            mem_raddr_o = idx_inc[AW-1:0];
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      value_q       <= '0;
      carry_q       <= '0;
      found_q       <= 1'b0;
      resp_q        <= osq_pkg::ST_DONE;
      out_valid_q   <= 1'b0;
      out_status_q  <= osq_pkg::ST_DONE;
      out_entry_q   <= '0;
      out_present_q <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      value_q       <= value_d;
      carry_q       <= carry_d;
      found_q       <= found_d;
      resp_q        <= resp_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_entry_q   <= out_entry_d;
      out_present_q <= out_present_d;
      out_last_q    <= out_last_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.entry         = out_entry_q;
  assign res_o.entry_present = out_present_q;
  assign res_o.last          = out_last_q;

endmodule

[hdl/ordered_sequence_store_top.sv]
// ordered sequence store: a bounded list of signed 32-bit values
// cmd_i carries one command per transaction (append, ordered insert,
// delete first match, dump); res_o returns the result transactions.
// append, delete and insert give one status transaction with last set;
// a dump gives one transaction per stored entry, last set on the final
// one, or a single empty transaction when nothing is stored.
// insert and delete walk the list through the single read port of the
// entry memory, one entry per cycle; a dump delivers one entry per cycle
// while the receiver does not stall.
// a new command is taken only when the previous one has finished its
// memory pass; a finished result may still sit in the output register.
// reset empties the list at once (count cleared), the memory is not swept.
// when the receiver stalls, the output register holds its transaction and
// the pass waits at its next result; nothing is dropped or repeated.
module ordered_sequence_store_top #(
  parameter int unsigned CAPACITY = osq_pkg::CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  osq_cmd_if.sink    cmd_i,
  osq_res_if.source  res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [osq_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [osq_pkg::DATA_W-1:0] mem_rdata;

  // sequencer and output register
  osq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry storage
  osq_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
